/* src/epp_pkg.sv */
// Shared types, constants and arithmetic helpers of the Euler pose point transform.
`timescale 1ns / 1ps
package epp_pkg;

	localparam int CORD_W = 34;
	localparam int ATAN_ENTRIES = 24;

	localparam logic signed [CORD_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	localparam logic signed [CORD_W-1:0] Q30_ONE = 34'sd1073741824;
	localparam logic signed [63:0] Q30_HALF = 64'sd536870912;

	localparam logic [2:0] REG_TRANS_X = 3'd0;
	localparam logic [2:0] REG_TRANS_Y = 3'd1;
	localparam logic [2:0] REG_TRANS_Z = 3'd2;
	localparam logic [2:0] REG_ROLL = 3'd3;
	localparam logic [2:0] REG_PITCH = 3'd4;
	localparam logic [2:0] REG_YAW = 3'd5;

	localparam logic [31:0] ATAN_PHASE [0:ATAN_ENTRIES-1] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef logic signed [31:0] q30_t;

	typedef struct packed {
		q30_t m0;
		q30_t m1;
		q30_t m2;
	} mrow_t;

	function automatic q30_t clamp_unit(input logic signed [CORD_W-1:0] v);
		if (v > Q30_ONE) begin
			return Q30_ONE[31:0];
		end else if (v < -Q30_ONE) begin
			return -Q30_ONE[31:0];
		end
		return v[31:0];
	endfunction

	function automatic q30_t qmul(input q30_t a, input q30_t b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b) + Q30_HALF;
		return p[61:30];
	endfunction

endpackage

/* src/euler_pose_point_transform.sv */
// Top level of the Euler pose point transform: configuration, lanes and output merge.
// Usage:
//   Write translation and roll, pitch and yaw through cfg_we, cfg_index and cfg_data
//   while no transaction is in flight. Points enter on the s_axis channel
//   (tdata: point_x, point_y, point_z from bit 0 up). Each point gives one
//   result on m_axis (tdata: out_x, out_y, out_z; tuser: saturated).
//   A point passes through three register stages (lane products, lane sums and
//   the output register) before its result is offered on m_axis. Throughput is
//   one point per cycle, set by the three multiply lanes, while m_axis takes results.
//   After reset and after any configuration write the rotation pipeline
//   (CORDIC_STEPS + 5 stages of CORDIC and matrix products) refills, and
//   s_axis_tready stays low until the warm-up counter has counted down.
//   When the receiver stalls the whole point pipeline holds, and outside the refill
//   input is refused only once the output register is full and not being taken.
//   Reset clears the configuration registers to zero, empties the point pipeline and restarts the refill.
`timescale 1ns / 1ps
module euler_pose_point_transform import epp_pkg::*; #(
	parameter int ANGLE_BITS = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [95:0]  s_axis_tdata,  // point_x, point_y, point_z
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [95:0]  m_axis_tdata,  // out_x, out_y, out_z
	output logic [0:0]   m_axis_tuser   // saturated
);

	localparam int WARM = CORDIC_STEPS + 6;
	localparam int WARM_W = $clog2(WARM + 1);

	logic signed [31:0] tx_q, ty_q, tz_q;
	logic [15:0] roll_q, pitch_q, yaw_q;
	logic [WARM_W-1:0] warm_q;
	logic v1_s1, v2_s2;
	logic ce;
	logic accept;
	q30_t cr, sr, cp, sp, cy, sy;
	mrow_t row0, row1, row2;
	logic signed [36:0] sx_s2, sy_s2, sz_s2;
	logic [31:0] ox, oy, oz;
	logic fx, fy, fz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_q <= '0;
			ty_q <= '0;
			tz_q <= '0;
			roll_q <= '0;
			pitch_q <= '0;
			yaw_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TRANS_X: tx_q <= cfg_data;
				REG_TRANS_Y: ty_q <= cfg_data;
				REG_TRANS_Z: tz_q <= cfg_data;
				REG_ROLL: roll_q <= cfg_data[15:0];
				REG_PITCH: pitch_q <= cfg_data[15:0];
				REG_YAW: yaw_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q <= WARM_W'(WARM);
		end else if (cfg_we) begin
			warm_q <= WARM_W'(WARM);
		end else if (warm_q != '0) begin
			warm_q <= warm_q - 1'b1;
		end
	end

	epp_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_roll (
		.clk(clk), .angle(roll_q), .cos_q30(cr), .sin_q30(sr));
	epp_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
		.clk(clk), .angle(pitch_q), .cos_q30(cp), .sin_q30(sp));
	epp_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
		.clk(clk), .angle(yaw_q), .cos_q30(cy), .sin_q30(sy));

	epp_matrix u_matrix (
		.clk(clk), .cr(cr), .sr(sr), .cp(cp), .sp(sp), .cy(cy), .sy(sy),
		.row0(row0), .row1(row1), .row2(row2));

	assign ce = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = ce && (warm_q == '0);
	assign accept = s_axis_tvalid && s_axis_tready;

	epp_lane u_lane_x (
		.clk(clk), .ce(ce), .row(row0), .px(s_axis_tdata[31:0]), .py(s_axis_tdata[63:32]),
		.pz(s_axis_tdata[95:64]), .trans(tx_q), .sum_s2(sx_s2));
	epp_lane u_lane_y (
		.clk(clk), .ce(ce), .row(row1), .px(s_axis_tdata[31:0]), .py(s_axis_tdata[63:32]),
		.pz(s_axis_tdata[95:64]), .trans(ty_q), .sum_s2(sy_s2));
	epp_lane u_lane_z (
		.clk(clk), .ce(ce), .row(row2), .px(s_axis_tdata[31:0]), .py(s_axis_tdata[63:32]),
		.pz(s_axis_tdata[95:64]), .trans(tz_q), .sum_s2(sz_s2));

	always_comb begin
		fx = (sx_s2 > 37'sd2147483647) || (sx_s2 < -37'sd2147483648);
		fy = (sy_s2 > 37'sd2147483647) || (sy_s2 < -37'sd2147483648);
		fz = (sz_s2 > 37'sd2147483647) || (sz_s2 < -37'sd2147483648);
		ox = fx ? (sx_s2[36] ? 32'h80000000 : 32'h7FFFFFFF) : sx_s2[31:0];
		oy = fy ? (sy_s2[36] ? 32'h80000000 : 32'h7FFFFFFF) : sy_s2[31:0];
		oz = fz ? (sz_s2[36] ? 32'h80000000 : 32'h7FFFFFFF) : sz_s2[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else if (ce) begin
			v1_s1 <= accept;
			v2_s2 <= v1_s1;
			m_axis_tvalid <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			m_axis_tdata <= {oz, oy, ox};
			m_axis_tuser <= fx || fy || fz;
		end
	end

endmodule

/* src/epp_cordic.sv */
// Pipelined rotation-mode CORDIC giving the cosine and sine of one binary angle in Q2.30.
`timescale 1ns / 1ps
module epp_cordic import epp_pkg::*; #(
	parameter int ANGLE_BITS = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic [15:0] angle,
	output q30_t        cos_q30,
	output q30_t        sin_q30
);

	localparam int SH = 32 - ANGLE_BITS;
	localparam logic [31:0] AMASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

	logic [31:0] ph;
	logic [31:0] ph_off;
	logic [1:0]  quad;
	logic [31:0] resid;

	logic signed [CORD_W-1:0] x_q [0:CORDIC_STEPS];
	logic signed [CORD_W-1:0] y_q [0:CORDIC_STEPS];
	logic signed [CORD_W-1:0] z_q [0:CORDIC_STEPS];
	logic [1:0]               q_q [0:CORDIC_STEPS];
	logic signed [CORD_W-1:0] c_pre;
	logic signed [CORD_W-1:0] s_pre;

	assign ph = ({16'd0, angle} & AMASK) << SH;
	assign ph_off = ph + 32'h20000000;
	assign quad = ph_off[31:30];
	assign resid = ph - {quad, 30'd0};

	always_ff @(posedge clk) begin
		x_q[0] <= CORDIC_GAIN_Q30;
		y_q[0] <= '0;
		z_q[0] <= CORD_W'(signed'(resid));
		q_q[0] <= quad;
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		localparam logic signed [CORD_W-1:0] ATN = CORD_W'(ATAN_PHASE[i]);
		always_ff @(posedge clk) begin
			if (z_q[i] >= 0) begin
				x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
				y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
				z_q[i+1] <= z_q[i] - ATN;
			end else begin
				x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
				y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
				z_q[i+1] <= z_q[i] + ATN;
			end
			q_q[i+1] <= q_q[i];
		end
	end

	always_comb begin
		case (q_q[CORDIC_STEPS])
			2'd1: begin
				c_pre = -y_q[CORDIC_STEPS];
				s_pre = x_q[CORDIC_STEPS];
			end
			2'd2: begin
				c_pre = -x_q[CORDIC_STEPS];
				s_pre = -y_q[CORDIC_STEPS];
			end
			2'd3: begin
				c_pre = y_q[CORDIC_STEPS];
				s_pre = -x_q[CORDIC_STEPS];
			end
			default: begin
				c_pre = x_q[CORDIC_STEPS];
				s_pre = y_q[CORDIC_STEPS];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		cos_q30 <= clamp_unit(c_pre);
		sin_q30 <= clamp_unit(s_pre);
	end

endmodule

/* src/epp_matrix.sv */
// ZYX rotation matrix built from the three sine and cosine pairs over three registered stages.
`timescale 1ns / 1ps
module epp_matrix import epp_pkg::*; (
	input  logic  clk,
	input  q30_t  cr,
	input  q30_t  sr,
	input  q30_t  cp,
	input  q30_t  sp,
	input  q30_t  cy,
	input  q30_t  sy,
	output mrow_t row0,
	output mrow_t row1,
	output mrow_t row2
);

	q30_t cycp_s1, cysp_s1, sysp_s1, sycp_s1, sycr_s1, sysr_s1, cycr_s1, cysr_s1;
	q30_t cpsr_s1, cpcr_s1, sp_s1, sr_s1, cr_s1;
	q30_t a01_s2, a02_s2, a11_s2, a12_s2;
	q30_t cycp_s2, sycp_s2, sycr_s2, sysr_s2, cycr_s2, cysr_s2, cpsr_s2, cpcr_s2, sp_s2;

	always_ff @(posedge clk) begin
		cycp_s1 <= qmul(cy, cp);
		cysp_s1 <= qmul(cy, sp);
		sysp_s1 <= qmul(sy, sp);
		sycp_s1 <= qmul(sy, cp);
		sycr_s1 <= qmul(sy, cr);
		sysr_s1 <= qmul(sy, sr);
		cycr_s1 <= qmul(cy, cr);
		cysr_s1 <= qmul(cy, sr);
		cpsr_s1 <= qmul(cp, sr);
		cpcr_s1 <= qmul(cp, cr);
		sp_s1 <= sp;
		sr_s1 <= sr;
		cr_s1 <= cr;
	end

	always_ff @(posedge clk) begin
		a01_s2 <= qmul(cysp_s1, sr_s1);
		a02_s2 <= qmul(cysp_s1, cr_s1);
		a11_s2 <= qmul(sysp_s1, sr_s1);
		a12_s2 <= qmul(sysp_s1, cr_s1);
		cycp_s2 <= cycp_s1;
		sycp_s2 <= sycp_s1;
		sycr_s2 <= sycr_s1;
		sysr_s2 <= sysr_s1;
		cycr_s2 <= cycr_s1;
		cysr_s2 <= cysr_s1;
		cpsr_s2 <= cpsr_s1;
		cpcr_s2 <= cpcr_s1;
		sp_s2 <= sp_s1;
	end

	always_ff @(posedge clk) begin
		row0.m0 <= clamp_unit(CORD_W'(cycp_s2));
		row0.m1 <= clamp_unit(CORD_W'(a01_s2) - CORD_W'(sycr_s2));
		row0.m2 <= clamp_unit(CORD_W'(a02_s2) + CORD_W'(sysr_s2));
		row1.m0 <= clamp_unit(CORD_W'(sycp_s2));
		row1.m1 <= clamp_unit(CORD_W'(a11_s2) + CORD_W'(cycr_s2));
		row1.m2 <= clamp_unit(CORD_W'(a12_s2) - CORD_W'(cysr_s2));
		row2.m0 <= clamp_unit(-CORD_W'(sp_s2));
		row2.m1 <= clamp_unit(CORD_W'(cpsr_s2));
		row2.m2 <= clamp_unit(CORD_W'(cpcr_s2));
	end

endmodule

/* src/epp_lane.sv */
// One output row: dot product of a matrix row with the point, rounded and translated.
`timescale 1ns / 1ps
module epp_lane import epp_pkg::*; (
	input  logic               clk,
	input  logic               ce,
	input  mrow_t              row,
	input  logic signed [31:0] px,
	input  logic signed [31:0] py,
	input  logic signed [31:0] pz,
	input  logic signed [31:0] trans,
	output logic signed [36:0] sum_s2
);

	logic signed [63:0] p0_s1, p1_s1, p2_s1;
	logic signed [65:0] acc;

	assign acc = 66'(p0_s1) + 66'(p1_s1) + 66'(p2_s1) + 66'(Q30_HALF);

	always_ff @(posedge clk) begin
		if (ce) begin
			p0_s1 <= 64'(row.m0) * 64'(px);
			p1_s1 <= 64'(row.m1) * 64'(py);
			p2_s1 <= 64'(row.m2) * 64'(pz);
			sum_s2 <= 37'(signed'(acc[65:30])) + 37'(trans);
		end
	end

endmodule

/* bench/tb.sv */
// Testbench for the Euler pose point transform: predicts each transformed point and checks it.
`timescale 1ns / 1ps
module tb;
	import epp_pkg::*;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic sat;
	} pose_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [95:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [95:0] m_axis_tdata;
	logic [0:0] m_axis_tuser;

	euler_pose_point_transform DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	longint pose_regs [0:5];
	pose_out_t expected_points [$];
	int error_count = 0;
	int hold_off = 0;
	bit stall_mode = 0;

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint unit_clamp(longint v);
		if (v > 64'sd1073741824) return 64'sd1073741824;
		if (v < -64'sd1073741824) return -64'sd1073741824;
		return v;
	endfunction

	function automatic longint fx_mul(longint a, longint b);
		return floor_shift(a * b + 64'sd536870912, 30);
	endfunction

	task automatic angle_sincos(input longint ang, output longint c, output longint s);
		logic [31:0] ph;
		logic [1:0] q;
		logic [31:0] res;
		longint x, y, z, nx;
		ph = {ang[15:0], 16'h0};
		q = 2'((ph + 32'h20000000) >> 30);
		res = ph - ({30'd0, q} << 30);
		z = longint'(signed'(res));
		x = 652032874;
		y = 0;
		for (int i = 0; i < 16; i++) begin
			if (z >= 0) begin
				nx = x - floor_shift(y, i);
				y = y + floor_shift(x, i);
				z -= longint'(ATAN_PHASE[i]);
			end else begin
				nx = x + floor_shift(y, i);
				y = y - floor_shift(x, i);
				z += longint'(ATAN_PHASE[i]);
			end
			x = nx;
		end
		case (q)
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			2'd3: begin c = y; s = -x; end
			default: begin c = x; s = y; end
		endcase
		c = unit_clamp(c);
		s = unit_clamp(s);
	endtask

	task automatic predict_point(input logic [95:0] pt, output pose_out_t res);
		longint cr, sr, cp, sp, cy, sy, acc, o;
		longint m [0:2][0:2];
		longint p [0:2];
		logic signed [31:0] outs [0:2];
		angle_sincos(pose_regs[3], cr, sr);
		angle_sincos(pose_regs[4], cp, sp);
		angle_sincos(pose_regs[5], cy, sy);
		m[0][0] = fx_mul(cy, cp);
		m[0][1] = fx_mul(fx_mul(cy, sp), sr) - fx_mul(sy, cr);
		m[0][2] = fx_mul(fx_mul(cy, sp), cr) + fx_mul(sy, sr);
		m[1][0] = fx_mul(sy, cp);
		m[1][1] = fx_mul(fx_mul(sy, sp), sr) + fx_mul(cy, cr);
		m[1][2] = fx_mul(fx_mul(sy, sp), cr) - fx_mul(cy, sr);
		m[2][0] = -sp;
		m[2][1] = fx_mul(cp, sr);
		m[2][2] = fx_mul(cp, cr);
		for (int k = 0; k < 3; k++) p[k] = longint'(signed'(pt[32*k +: 32]));
		res.sat = 1'b0;
		for (int k = 0; k < 3; k++) begin
			acc = 0;
			for (int j = 0; j < 3; j++) acc += unit_clamp(m[k][j]) * p[j];
			o = floor_shift(acc + 64'sd536870912, 30) + pose_regs[k];
			if (o > 64'sd2147483647) begin o = 64'sd2147483647; res.sat = 1'b1; end
			if (o < -64'sd2147483648) begin o = -64'sd2147483648; res.sat = 1'b1; end
			outs[k] = o[31:0];
		end
		res.x = outs[0];
		res.y = outs[1];
		res.z = outs[2];
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx < 3) pose_regs[idx] = longint'(signed'(val));
		else if (idx < 6) pose_regs[idx] = longint'(val[15:0]);
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (expected_points.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_pose(input logic [31:0] tx, ty, tz, input logic [15:0] r, p, y);
		wait_drained();
		write_reg(REG_TRANS_X, tx);
		write_reg(REG_TRANS_Y, ty);
		write_reg(REG_TRANS_Z, tz);
		write_reg(REG_ROLL, {16'h0, r});
		write_reg(REG_PITCH, {16'h0, p});
		write_reg(REG_YAW, {16'h0, y});
	endtask

	task automatic send_point(input logic [95:0] pt, input bit with_gaps);
		pose_out_t res;
		if (with_gaps && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pt;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_point(pt, res);
		expected_points = {expected_points, res};
	endtask

	task automatic idle_sender();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [95:0] rand_point(int mode);
		logic [95:0] v;
		for (int k = 0; k < 3; k++) begin
			case (mode)
				0: v[32*k +: 32] = $urandom;
				default: v[32*k +: 32] = 32'($signed($urandom_range(0, 2000000)) - 1000000);
			endcase
		end
		return v;
	endfunction

	always @(posedge clk) begin
		pose_out_t e;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_points.size() == 0) begin
				$error("unexpected result transaction %h", m_axis_tdata);
				error_count++;
			end else begin
				e = expected_points.pop_front();
				if (m_axis_tdata[31:0] !== e.x) begin
					$error("out_x expected %h got %h", e.x, m_axis_tdata[31:0]);
					error_count++;
				end
				if (m_axis_tdata[63:32] !== e.y) begin
					$error("out_y expected %h got %h", e.y, m_axis_tdata[63:32]);
					error_count++;
				end
				if (m_axis_tdata[95:64] !== e.z) begin
					$error("out_z expected %h got %h", e.z, m_axis_tdata[95:64]);
					error_count++;
				end
				if (m_axis_tuser[0] !== e.sat) begin
					$error("saturated expected %b got %b", e.sat, m_axis_tuser[0]);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_off > 0) begin
			m_axis_tready <= 1'b0;
			hold_off <= hold_off - 1;
		end else if (!stall_mode) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(0, 2) != 0);
		end
	end

	task automatic test_reset_pose();
		send_point({32'h0001_0000, 32'h0002_0000, 32'h0003_0000}, 0);
		send_point({32'h7FFF_FFFF, 32'h8000_0000, 32'h0}, 0);
		idle_sender();
	endtask

	task automatic test_directed_poses();
		logic [15:0] angs [0:7];
		angs = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h2000, 16'hFFFF, 16'h0001, 16'h6000};
		for (int i = 0; i < 8; i++) begin
			set_pose(32'h0000_8000, 32'hFFFF_0000, 32'h0, angs[i], angs[(i+3)%8], angs[(i+5)%8]);
			send_point({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 0);
			send_point({32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 0);
			idle_sender();
		end
		set_pose(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0, 16'h0, 16'h0);
		send_point({32'h0100_0000, 32'h8000_0000, 32'h7FFF_FFFF}, 0);
		send_point({32'h0, 32'h0, 32'h0}, 0);
		idle_sender();
		wait_drained();
		write_reg(3'd6, 32'hFFFF_FFFF);
		write_reg(3'd7, 32'h1234_5678);
		send_point({32'h0, 32'h1_0000, 32'h0}, 0);
		idle_sender();
	endtask

	task automatic test_random_stream();
		int sent;
		sent = 0;
		stall_mode = 1;
		while (sent < 800) begin
			if (sent % 100 == 0) begin
				set_pose($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
					16'($urandom));
				if ($urandom_range(0, 1)) begin
					pose_regs[0] = 0;
					write_reg(REG_TRANS_X, 32'h0);
				end
			end
			repeat ($urandom_range(1, 20)) begin
				send_point(rand_point($urandom_range(0, 3)), 1);
				sent++;
			end
			idle_sender();
			repeat ($urandom_range(0, 5)) @(posedge clk);
			if (sent % 250 < 20) stall_mode = 0;
			else stall_mode = 1;
		end
		idle_sender();
	endtask

	task automatic test_back_pressure();
		stall_mode = 0;
		hold_off = 60;
		@(posedge clk);
		for (int i = 0; i < 30; i++) send_point(rand_point(1), 0);
		idle_sender();
		wait_drained();
		for (int i = 0; i < 10; i++) send_point(rand_point(0), 0);
		idle_sender();
	endtask

	initial begin
		for (int i = 0; i < 6; i++) pose_regs[i] = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_pose();
		test_directed_poses();
		test_random_stream();
		test_back_pressure();
		wait_drained();
		repeat (20) @(posedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
